// ----- sv/scp_pkg.sv -----
// Shared widths, constants and controller/datapath types for the page replacer.
package scp_pkg;

  localparam int FRAMES  = 8;
  localparam int PAGES   = 16;
  localparam int PAGE_W  = $clog2(PAGES);
  localparam int FIDX_W  = $clog2(FRAMES);
  localparam int RANK_W  = $clog2(FRAMES);
  localparam int USED_W  = $clog2(FRAMES + 1);
  localparam int CFG_W   = 4;
  localparam int CNT_W   = 16;

  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(FRAMES);
  localparam logic [CNT_W-1:0] CNT_MAX   = '1;

  typedef logic [PAGE_W-1:0] page_t;
  typedef logic [FIDX_W-1:0] fidx_t;
  typedef logic [RANK_W-1:0] rank_t;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_LOOK   = 3'b010,
    S_COMMIT = 3'b100
  } scp_state_t;

  typedef struct packed {
    logic accept;   // latch the referenced page
    logic look;     // register lookup and victim choice
    logic commit;   // update frame state and load the result register
  } scp_cmd_t;

  typedef struct packed {
    logic out_full; // result register holds an untaken transaction
  } scp_status_t;

endpackage

// ----- sv/scp_if.sv -----
// Valid/ready channel interfaces for page references and replacement results.
interface scp_in_if import scp_pkg::*; ();
  logic  valid;
  logic  ready;
  page_t page;

  modport source(output valid, output page, input ready);
  modport sink(input valid, input page, output ready);
endinterface

interface scp_out_if import scp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             fault;
  logic             evicted_valid;
  page_t            evicted_page;
  logic [CNT_W-1:0] fault_count;

  modport source(output valid, output fault, output evicted_valid, output evicted_page,
                 output fault_count, input ready);
  modport sink(input valid, input fault, input evicted_valid, input evicted_page,
               input fault_count, output ready);
endinterface

// ----- sv/scp_ctrl.sv -----
// Sequencer for accept, lookup and commit of one page reference.
module scp_ctrl import scp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        out_ready,
  input  scp_status_t status,
  output scp_cmd_t    cmd
);

  scp_state_t state_r, state_nxt;

  always_comb begin
    in_ready   = (state_r == S_IDLE);
    cmd.accept = in_valid && (state_r == S_IDLE);
    cmd.look   = (state_r == S_LOOK);
    // commit only when the result register is free or being drained
    cmd.commit = (state_r == S_COMMIT) && (!status.out_full || out_ready);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (cmd.accept) state_nxt = S_LOOK;
      S_LOOK:   state_nxt = S_COMMIT;
      S_COMMIT: if (cmd.commit) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- sv/scp_datapath.sv -----
// Frame table, lookup and victim selection, state update and result register.
module scp_datapath import scp_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata,
  input  scp_cmd_t         cmd,
  output scp_status_t      status,
  input  page_t            in_page,
  input  logic             out_ready,
  output logic             out_valid,
  output logic             out_fault,
  output logic             out_evicted_valid,
  output page_t            out_evicted_page,
  output logic [CNT_W-1:0] out_fault_count
);

  logic [CFG_W-1:0]  cfg_r;
  page_t             frame_page_r [FRAMES];
  page_t             frame_page_nxt [FRAMES];
  logic [FRAMES-1:0] valid_r, valid_nxt;
  logic [FRAMES-1:0] mark_r, mark_nxt;
  rank_t             rank_r [FRAMES];
  rank_t             rank_nxt [FRAMES];
  logic [CNT_W-1:0]  count_r, count_nxt;
  page_t             page_r;

  // lookup decisions
  logic  hit_any_r, free_any_r, unmarked_r;
  fidx_t hit_idx_r, free_idx_r, vic_idx_r;
  rank_t used_r;

  logic [CFG_W-1:0]  win_n;
  logic [FRAMES-1:0] win, hit_vec, free_vec, cand_vec, sel_mask;
  fidx_t             hit_idx, free_idx, vic_idx;
  logic [USED_W-1:0] used_cnt;
  logic              vic_found;

  logic             out_valid_r, out_valid_nxt;
  logic             out_fault_r, out_fault_nxt;
  logic             out_ev_valid_r, out_ev_valid_nxt;
  page_t            out_ev_page_r, out_ev_page_nxt;
  logic [CNT_W-1:0] out_count_r, out_count_nxt;

  rank_t vr;
  logic  older;

  // window size: zero acts as one, above FRAMES acts as FRAMES
  always_comb begin
    if (cfg_r == '0) begin
      win_n = CFG_W'(1);
    end else if (cfg_r > CFG_W'(FRAMES)) begin
      win_n = CFG_W'(FRAMES);
    end else begin
      win_n = cfg_r;
    end
    for (int i = 0; i < FRAMES; i++) begin
      win[i] = (CFG_W'(i) < win_n);
    end
  end

  always_comb begin
    hit_idx   = '0;
    free_idx  = '0;
    vic_idx   = '0;
    vic_found = 1'b0;
    used_cnt  = '0;
    for (int i = 0; i < FRAMES; i++) begin
      hit_vec[i]  = win[i] && valid_r[i] && (frame_page_r[i] == page_r);
      free_vec[i] = win[i] && !valid_r[i];
      cand_vec[i] = win[i] && !mark_r[i];
      used_cnt    = used_cnt + USED_W'(win[i] && valid_r[i]);
    end
    for (int i = FRAMES - 1; i >= 0; i--) begin
      if (hit_vec[i]) hit_idx = FIDX_W'(i);
      if (free_vec[i]) free_idx = FIDX_W'(i);
    end
    // oldest of the unmarked frames, or of the whole window if all are marked
    sel_mask = (|cand_vec) ? cand_vec : win;
    for (int i = 0; i < FRAMES; i++) begin
      if (sel_mask[i] && (!vic_found || rank_r[i] < rank_r[vic_idx])) begin
        vic_idx   = FIDX_W'(i);
        vic_found = 1'b1;
      end
    end
  end

  always_comb begin
    frame_page_nxt   = frame_page_r;
    valid_nxt        = valid_r;
    mark_nxt         = mark_r;
    rank_nxt         = rank_r;
    count_nxt        = count_r;
    out_fault_nxt    = out_fault_r;
    out_ev_valid_nxt = out_ev_valid_r;
    out_ev_page_nxt  = out_ev_page_r;
    out_count_nxt    = out_count_r;
    out_valid_nxt    = out_valid_r && !out_ready;
    vr               = rank_r[vic_idx_r];
    older            = 1'b0;
    if (cmd.commit) begin
      out_valid_nxt    = 1'b1;
      out_fault_nxt    = !hit_any_r;
      out_ev_valid_nxt = 1'b0;
      out_ev_page_nxt  = '0;
      if (hit_any_r) begin
        mark_nxt[hit_idx_r] = 1'b1;
      end else begin
        if (count_r != CNT_MAX) count_nxt = count_r + CNT_W'(1);
        if (free_any_r) begin
          frame_page_nxt[free_idx_r] = page_r;
          valid_nxt[free_idx_r]      = 1'b1;
          mark_nxt[free_idx_r]       = 1'b0;
          rank_nxt[free_idx_r]       = used_r;
        end else begin
          out_ev_valid_nxt = 1'b1;
          out_ev_page_nxt  = frame_page_r[vic_idx_r];
          for (int i = 0; i < FRAMES; i++) begin
            older = (rank_r[i] < vr) || ((rank_r[i] == vr) && (FIDX_W'(i) < vic_idx_r));
            if (win[i]) begin
              // clear marks of older frames, or all marks if none was clear
              if (!unmarked_r || older) mark_nxt[i] = 1'b0;
              if (rank_r[i] > vr) rank_nxt[i] = rank_r[i] - RANK_W'(1);
            end
          end
          frame_page_nxt[vic_idx_r] = page_r;
          mark_nxt[vic_idx_r]       = 1'b0;
          rank_nxt[vic_idx_r]       = RANK_W'(win_n - CFG_W'(1));
        end
      end
      out_count_nxt = count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r       <= CFG_RESET;
      valid_r     <= '0;
      mark_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < FRAMES; i++) begin
        rank_r[i] <= '0;
      end
    end else begin
      if (cfg_we) cfg_r <= cfg_wdata;
      valid_r     <= valid_nxt;
      mark_r      <= mark_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      rank_r      <= rank_nxt;
    end
  end

  always_ff @(posedge clk) begin
    frame_page_r   <= frame_page_nxt;
    out_fault_r    <= out_fault_nxt;
    out_ev_valid_r <= out_ev_valid_nxt;
    out_ev_page_r  <= out_ev_page_nxt;
    out_count_r    <= out_count_nxt;
    if (cmd.accept) page_r <= in_page;
    if (cmd.look) begin
      hit_any_r  <= |hit_vec;
      hit_idx_r  <= hit_idx;
      free_any_r <= |free_vec;
      free_idx_r <= free_idx;
      used_r     <= used_cnt[RANK_W-1:0];
      vic_idx_r  <= vic_idx;
      unmarked_r <= |cand_vec;
    end
  end

  assign status.out_full   = out_valid_r;
  assign out_valid         = out_valid_r;
  assign out_fault         = out_fault_r;
  assign out_evicted_valid = out_ev_valid_r;
  assign out_evicted_page  = out_ev_page_r;
  assign out_fault_count   = out_count_r;

endmodule

// ----- sv/second_chance_page_replacer_unit.sv -----
// Top level of the second-chance page replacer: controller, datapath and checks.
//
//   channel  direction  handshake      payload
//   in_if    sink       valid/ready    page[3:0]
//   out_if   source     valid/ready    fault, evicted_valid, evicted_page[3:0],
//                                      fault_count[15:0]
//   cfg_*    input      cfg_we         cfg_wdata[3:0] = frames_in_use
//
// Each reference passes through accept, lookup with victim choice over the
// frames in the window, then commit of the frame table into the result register.
// The commit cycle stalls while the result register still holds a transaction
// that out_if has not taken; in_ready stays low until that commit is done.
// Reset (rst_n low at a clock edge) empties all frames, clears marks, ranks and
// the fault count, and sets frames_in_use to 8. Page numbers need no clearing.
module second_chance_page_replacer_unit import scp_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata,
  scp_in_if.sink           in_if,
  scp_out_if.source        out_if
);

  scp_cmd_t    cmd;
  scp_status_t status;

  // Sequence one reference at a time: accept, look, commit.
  scp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .out_ready (out_if.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Hold the frame table and drive the result register.
  scp_datapath u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .cmd               (cmd),
    .status            (status),
    .in_page           (in_if.page),
    .out_ready         (out_if.ready),
    .out_valid         (out_if.valid),
    .out_fault         (out_if.fault),
    .out_evicted_valid (out_if.evicted_valid),
    .out_evicted_page  (out_if.evicted_page),
    .out_fault_count   (out_if.fault_count)
  );

  // An accepted transaction drops ready until its result is committed.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |=> !in_if.ready)
    else $error("in_ready high in the cycle after an accept");

  // An eviction only happens on a fault.
  a_evict_needs_fault: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && out_if.evicted_valid |-> out_if.fault)
    else $error("eviction reported without a fault");

  // Nothing evicted reports page zero.
  a_evict_page_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && !out_if.evicted_valid |-> out_if.evicted_page == '0)
    else $error("evicted_page nonzero without eviction");

  // A commit never overwrites an untaken result.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> !status.out_full || out_if.ready)
    else $error("result register overwritten");

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the second-chance page replacer unit.
module testbench;
  import scp_pkg::*;

  // Keep the cycle budget generous: the only long quiet stretch is the
  // receiver hold-off; everything else keeps transactions moving.
  localparam int HALF_PERIOD   = 2;
  localparam int RESET_CYCLES  = 7;
  localparam int IDLE_PCT      = 27;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 6;
  localparam int STALL_LIMIT   = 2000;
  localparam int PHASE_ITEMS   = 100;
  localparam int REPORT_MAX    = 10;
  localparam int DIRECTED_ROWS = 28;
  localparam int PHASES        = 14;

  typedef struct packed {
    logic             fault;
    logic             evicted_valid;
    page_t            evicted_page;
    logic [CNT_W-1:0] fault_count;
  } ref_outcome_t;

  // A directed row either references a page or resizes the frame window.
  typedef enum logic {ROW_REF, ROW_WINDOW} row_kind_t;

  typedef struct packed {
    row_kind_t    kind;
    logic [3:0]   value;
    logic         typed;
    ref_outcome_t want;
  } directed_row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_W-1:0] cfg_wdata;

  scp_in_if  in_ch ();
  scp_out_if out_ch ();

  second_chance_page_replacer_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_if     (in_ch),
    .out_if    (out_ch)
  );

  // Shadow copy of the frame table, mirrored at each accepted reference.
  page_t            frm_page  [FRAMES];
  logic             frm_valid [FRAMES];
  logic             frm_mark  [FRAMES];
  rank_t            frm_rank  [FRAMES];
  logic [CNT_W-1:0] faults_so_far;
  logic [CFG_W-1:0] window_cfg;

  ref_outcome_t pending_outcomes [$];
  int unsigned  mismatches;
  bit           calm;       // suppress random idling on both sides
  bit           hold_req;   // ask the receiver for one long hold-off

  // Directed stimulus. Typed rows carry results that follow directly from
  // reset and a plain fill; the rest fall back to the shadow frame table.
  directed_row_t directed_rows [DIRECTED_ROWS] = '{
    // fill all eight frames from empty
    '{ROW_REF, 4'd0, 1'b1, '{1'b1, 1'b0, 4'd0, 16'd1}},
    '{ROW_REF, 4'd1, 1'b1, '{1'b1, 1'b0, 4'd0, 16'd2}},
    '{ROW_REF, 4'd2, 1'b1, '{1'b1, 1'b0, 4'd0, 16'd3}},
    '{ROW_REF, 4'd3, 1'b1, '{1'b1, 1'b0, 4'd0, 16'd4}},
    '{ROW_REF, 4'd4, 1'b1, '{1'b1, 1'b0, 4'd0, 16'd5}},
    '{ROW_REF, 4'd5, 1'b1, '{1'b1, 1'b0, 4'd0, 16'd6}},
    '{ROW_REF, 4'd6, 1'b1, '{1'b1, 1'b0, 4'd0, 16'd7}},
    '{ROW_REF, 4'd7, 1'b1, '{1'b1, 1'b0, 4'd0, 16'd8}},
    // hit marks page 3, then a miss evicts the oldest unmarked page 0
    '{ROW_REF, 4'd3, 1'b1, '{1'b0, 1'b0, 4'd0, 16'd8}},
    '{ROW_REF, 4'd15, 1'b1, '{1'b1, 1'b1, 4'd0, 16'd9}},
    // mark every resident page
    '{ROW_REF, 4'd1, 1'b1, '{1'b0, 1'b0, 4'd0, 16'd9}},
    '{ROW_REF, 4'd2, 1'b1, '{1'b0, 1'b0, 4'd0, 16'd9}},
    '{ROW_REF, 4'd4, 1'b1, '{1'b0, 1'b0, 4'd0, 16'd9}},
    '{ROW_REF, 4'd5, 1'b1, '{1'b0, 1'b0, 4'd0, 16'd9}},
    '{ROW_REF, 4'd6, 1'b1, '{1'b0, 1'b0, 4'd0, 16'd9}},
    '{ROW_REF, 4'd7, 1'b1, '{1'b0, 1'b0, 4'd0, 16'd9}},
    '{ROW_REF, 4'd15, 1'b1, '{1'b0, 1'b0, 4'd0, 16'd9}},
    // all marks set: clear them all and evict the oldest
    '{ROW_REF, 4'd8, 1'b0, '0},
    '{ROW_REF, 4'd9, 1'b0, '0},
    // shrink the window; upper frames go dormant, ranks may tie
    '{ROW_WINDOW, 4'd3, 1'b0, '0},
    '{ROW_REF, 4'd9, 1'b0, '0},
    '{ROW_REF, 4'd4, 1'b0, '0},
    // zero acts as a single frame
    '{ROW_WINDOW, 4'd0, 1'b0, '0},
    '{ROW_REF, 4'd10, 1'b0, '0},
    '{ROW_REF, 4'd10, 1'b0, '0},
    // above range acts as all frames; dormant frames wake up again
    '{ROW_WINDOW, 4'd15, 1'b0, '0},
    '{ROW_REF, 4'd12, 1'b0, '0},
    '{ROW_REF, 4'd0, 1'b0, '0}
  };

  // Window values for the random phases, extremes and out-of-range included.
  logic [3:0] phase_windows [PHASES] = '{
    4'd1, 4'd8, 4'd2, 4'd0, 4'd6, 4'd15, 4'd3, 4'd8, 4'd5, 4'd1, 4'd7, 4'd4, 4'd9, 4'd8
  };

  always #HALF_PERIOD clk = ~clk;

  // Clamp a raw window setting to the usable frame count.
  function automatic int window_of(logic [CFG_W-1:0] raw);
    if (raw == 0) return 1;
    if (raw > FRAMES) return FRAMES;
    return int'(raw);
  endfunction

  // True when frame a was loaded before frame b; ties go to the lower frame.
  function automatic bit loaded_earlier(int a, int b);
    if (frm_rank[a] != frm_rank[b]) return frm_rank[a] < frm_rank[b];
    return a < b;
  endfunction

  // Apply one page reference to the shadow frame table and return the
  // outcome the block must report for it.
  function automatic ref_outcome_t replace_page(page_t pg);
    ref_outcome_t res;
    int n, used, hit, free_frame, victim, i;
    rank_t vrank;
    res        = '0;
    n          = window_of(window_cfg);
    used       = 0;
    hit        = -1;
    free_frame = -1;
    for (i = 0; i < n; i++) begin
      if (frm_valid[i]) begin
        used++;
        if (hit < 0 && frm_page[i] == pg) hit = i;
      end else if (free_frame < 0) begin
        free_frame = i;
      end
    end
    if (hit >= 0) begin
      frm_mark[hit] = 1'b1;
    end else begin
      res.fault = 1'b1;
      if (faults_so_far != CNT_MAX) faults_so_far++;
      if (free_frame >= 0) begin
        frm_page[free_frame]  = pg;
        frm_valid[free_frame] = 1'b1;
        frm_mark[free_frame]  = 1'b0;
        frm_rank[free_frame]  = rank_t'(used);
      end else begin
        // oldest unmarked frame; everything older loses its mark
        victim = -1;
        for (i = 0; i < n; i++)
          if (!frm_mark[i] && (victim < 0 || loaded_earlier(i, victim))) victim = i;
        if (victim >= 0) begin
          for (i = 0; i < n; i++)
            if (loaded_earlier(i, victim)) frm_mark[i] = 1'b0;
        end else begin
          // every mark set: clear all and take the oldest frame
          victim = 0;
          for (i = 0; i < n; i++) begin
            frm_mark[i] = 1'b0;
            if (loaded_earlier(i, victim)) victim = i;
          end
        end
        res.evicted_valid = 1'b1;
        res.evicted_page  = frm_page[victim];
        vrank = frm_rank[victim];
        for (i = 0; i < n; i++)
          if (frm_rank[i] > vrank) frm_rank[i]--;
        frm_page[victim] = pg;
        frm_mark[victim] = 1'b0;
        frm_rank[victim] = rank_t'(n - 1);
      end
    end
    res.fault_count = faults_so_far;
    return res;
  endfunction

  // Offer one page reference, idling at random first. Called and returns at
  // a falling edge; valid stays high so back-to-back items need no bubble.
  task automatic offer_page(input page_t pg, input logic typed, input ref_outcome_t want);
    ref_outcome_t predicted;
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.page  <= pg;
    do @(posedge clk); while (!in_ch.ready);
    // always advance the shadow table, even where the result is typed in
    predicted = replace_page(pg);
    pending_outcomes.push_back(typed ? want : predicted);
    @(negedge clk);
  endtask

  // Drop valid and wait until every expected transaction has come back.
  task automatic settle_block();
    in_ch.valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Resize the frame window; only ever done with the block idle.
  task automatic set_window(input logic [CFG_W-1:0] raw);
    settle_block();
    cfg_we    <= 1'b1;
    cfg_wdata <= raw;
    window_cfg = raw;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Result side: random back-pressure, plus one long hold-off on request
  // while the sender keeps pushing, so the block fills and stalls its input.
  initial begin : result_taker
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_ch.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Compare each returned transaction with the oldest outstanding one.
  always @(posedge clk) begin : result_check
    ref_outcome_t got, want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.fault, out_ch.evicted_valid, out_ch.evicted_page, out_ch.fault_count};
      if (pending_outcomes.size() == 0) begin
        if (mismatches < REPORT_MAX)
          $display("%0t: unexpected result fault=%0b ev=%0b ev_page=%0d count=%0d",
                   $realtime, got.fault, got.evicted_valid, got.evicted_page,
                   got.fault_count);
        mismatches++;
      end else begin
        want = pending_outcomes.pop_front();
        if (got.fault != want.fault || got.evicted_valid != want.evicted_valid ||
            got.evicted_page != want.evicted_page || got.fault_count != want.fault_count) begin
          if (mismatches < REPORT_MAX)
            $display("%0t: mismatch exp fault=%0b ev=%0b ev_page=%0d count=%0d / %s",
                     $realtime, want.fault, want.evicted_valid, want.evicted_page,
                     want.fault_count,
                     $sformatf("got fault=%0b ev=%0b ev_page=%0d count=%0d",
                               got.fault, got.evicted_valid, got.evicted_page,
                               got.fault_count));
          mismatches++;
        end
      end
    end
  end

  // Watchdog: end the run if no transaction moves on either channel for too long.
  always @(posedge clk) begin : stall_watch
    int unsigned quiet;
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int k, phase, item, eff;
    page_t pg, base;
    clk         = 1'b0;
    rst_n       = 1'b0;
    cfg_we      = 1'b0;
    cfg_wdata   = '0;
    in_ch.valid = 1'b0;
    in_ch.page  = '0;
    calm        = 1'b0;
    hold_req    = 1'b0;
    mismatches  = 0;
    stall_watch.quiet = 0;

    // shadow table mirrors the reset state
    for (k = 0; k < FRAMES; k++) begin
      frm_page[k]  = '0;
      frm_valid[k] = 1'b0;
      frm_mark[k]  = 1'b0;
      frm_rank[k]  = '0;
    end
    faults_so_far = '0;
    window_cfg    = CFG_RESET;

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part: walk the table.
    for (k = 0; k < DIRECTED_ROWS; k++) begin
      if (directed_rows[k].kind == ROW_WINDOW)
        set_window(directed_rows[k].value);
      else
        offer_page(page_t'(directed_rows[k].value), directed_rows[k].typed,
                   directed_rows[k].want);
    end

    // Random part: mostly references from a small working set a little
    // larger than the window, so hits, marks and second chances all occur.
    for (phase = 0; phase < PHASES; phase++) begin
      set_window(phase_windows[phase]);
      eff  = window_of(phase_windows[phase]);
      base = page_t'($urandom_range(0, PAGES - 1));
      calm = (phase == 7);
      for (item = 0; item < PHASE_ITEMS; item++) begin
        if (phase == 2 && item == 20) hold_req = 1'b1;
        if ($urandom_range(0, 99) < 75)
          pg = page_t'(base + $urandom_range(0, eff + 1));
        else
          pg = page_t'($urandom_range(0, PAGES - 1));
        offer_page(pg, 1'b0, '0);
      end
    end

    settle_block();
    repeat (SETTLE_CYCLES) @(negedge clk);

    if (pending_outcomes.size() != 0)
      $display("%0d expected transactions never arrived", pending_outcomes.size());
    if (mismatches == 0 && pending_outcomes.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
